/* src/otap_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otap_pkg
// Types and constants shared by the offset table parser and its channels.
// ----------------------------------------------------------------------------
package otap_pkg;

  localparam int WORD_W   = 32;
  localparam int OFF_W    = 31;
  localparam int IDX_W    = 18;
  // word index and word count hold up to 2^18 words
  localparam int CNT_W    = 19;
  localparam int MIN_SIZE = 8;

  typedef enum logic [2:0] {
    KIND_HEADER  = 3'd0,
    KIND_ENTRY   = 3'd1,
    KIND_FINAL   = 3'd2,
    KIND_ERROR   = 3'd3,
    KIND_IGNORED = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_BAD_LENGTH = 3'd1,
    ERR_BAD_COUNT  = 3'd2,
    ERR_DESCENDING = 3'd3,
    ERR_BEYOND     = 3'd4,
    ERR_FIRST_MISM = 3'd5,
    ERR_LAST_MISM  = 3'd6
  } err_t;

  typedef enum logic {
    PH_IDLE = 1'b0,
    PH_BODY = 1'b1
  } phase_t;

  typedef struct packed {
    logic              begins_table;
    logic [WORD_W-1:0] table_word;
  } in_item_t;

  typedef struct packed {
    kind_t             kind;
    logic [IDX_W-1:0]  entry_index;
    logic [OFF_W-1:0]  entry_offset;
    logic [OFF_W-1:0]  entry_size;
    logic              entry_flag;
    err_t              error_code;
  } out_item_t;

endpackage

/* src/otap_stream_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otap_stream_if
// Valid/ready channel carrying one item of a given payload type.
// ----------------------------------------------------------------------------
interface otap_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* src/offset_table_archive_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// offset_table_archive_parser
// Checks an archive offset table word by word against the archive size.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_if : write channel for archive_size; always ready. Write it only
//            while no item is in flight.
//   in_if  : one table word per item; begins_table marks the header word.
//   out_if : exactly one result item per input item (header ok, entry,
//            final entry, error or ignored).
// Output: the result is registered; out_if.valid rises in the cycle after accept.
// Throughput: 1 item per cycle unless out_if stalls; all checks are compares
//   against the size or stored table state, done ahead of the output register.
// Stall: a single output register holds the pending result; in_if.ready
//   stays high while that register is empty or being drained in the same
//   cycle, so a stalled receiver stalls the input after one item.
// Reset: rst_n (sync, active low) clears the size, the table state and the
//   output valid; the block is ready as soon as reset is released.
// Entries are tentative until the final entry or an error item arrives.
// ----------------------------------------------------------------------------
module offset_table_archive_parser #(
  parameter int MAX_TABLE_WORDS = 262144
) (
  input  logic                clk,
  input  logic                rst_n,
  otap_stream_if.sink         cfg_if,
  otap_stream_if.sink         in_if,
  otap_stream_if.source       out_if
);
  import otap_pkg::*;

  // configuration register
  logic [WORD_W-1:0] size_r;

  // table state
  phase_t            phase_r, phase_nxt;
  logic [CNT_W-1:0]  word_index_r, word_index_nxt;
  logic [CNT_W-1:0]  word_count_r, word_count_nxt;
  logic [OFF_W-1:0]  prev_off_r, prev_off_nxt;
  logic              prev_flag_r, prev_flag_nxt;

  // output register
  out_item_t         out_r, out_nxt;
  logic              out_valid_r;

  logic              accept;
  logic              begins;
  logic [WORD_W-1:0] word;
  logic [OFF_W-1:0]  masked;
  logic              flag;
  logic [WORD_W-3:0] n_words;

  logic              hdr_small, hdr_len_bad, hdr_cnt_bad, hdr_flag_bad, hdr_ok;
  logic              body_desc, body_beyond, body_last, body_last_bad;
  logic [CNT_W:0]    next_pos;

  assign in_if.ready  = !out_valid_r || out_if.ready;
  assign accept       = in_if.valid && in_if.ready;
  assign cfg_if.ready = 1'b1;

  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_r;

  assign begins  = in_if.data.begins_table;
  assign word    = in_if.data.table_word;
  assign masked  = word[OFF_W-1:0];
  assign flag    = word[WORD_W-1];
  assign n_words = word[WORD_W-1:2];

  // header checks
  assign hdr_small    = size_r < WORD_W'(MIN_SIZE);
  assign hdr_len_bad  = (word == '0) || (word[1:0] != 2'b00) || (word > size_r);
  assign hdr_cnt_bad  = (n_words < (WORD_W-2)'(2)) ||
                        (n_words > (WORD_W-2)'(MAX_TABLE_WORDS));
  assign hdr_flag_bad = flag;
  assign hdr_ok       = !hdr_small && !hdr_len_bad && !hdr_cnt_bad && !hdr_flag_bad;

  // body checks
  assign body_desc     = masked < prev_off_r;
  assign body_beyond   = {1'b0, masked} > size_r;
  assign next_pos      = {1'b0, word_index_r} + (CNT_W+1)'(1);
  assign body_last     = next_pos >= {1'b0, word_count_r};
  assign body_last_bad = {1'b0, masked} != size_r;

  // next table state
  always_comb begin
    phase_nxt      = phase_r;
    word_index_nxt = word_index_r;
    word_count_nxt = word_count_r;
    prev_off_nxt   = prev_off_r;
    prev_flag_nxt  = prev_flag_r;
    if (accept) begin
      if (begins) begin
        phase_nxt = PH_IDLE;
        if (hdr_ok) begin
          phase_nxt      = PH_BODY;
          word_count_nxt = n_words[CNT_W-1:0];
          word_index_nxt = CNT_W'(1);
          prev_off_nxt   = masked;
          prev_flag_nxt  = flag;
        end
      end else if (phase_r == PH_BODY) begin
        if (body_desc || body_beyond || (body_last && body_last_bad)) begin
          phase_nxt = PH_IDLE;
        end else begin
          if (body_last) begin
            phase_nxt = PH_IDLE;
          end
          word_index_nxt = next_pos[CNT_W-1:0];
          prev_off_nxt   = masked;
          prev_flag_nxt  = flag;
        end
      end
    end
  end

  // result item
  always_comb begin
    out_nxt            = '0;
    out_nxt.kind       = KIND_IGNORED;
    out_nxt.error_code = ERR_NONE;
    if (begins) begin
      if (hdr_small || hdr_len_bad) begin
        out_nxt.kind       = KIND_ERROR;
        out_nxt.error_code = ERR_BAD_LENGTH;
      end else if (hdr_cnt_bad) begin
        out_nxt.kind       = KIND_ERROR;
        out_nxt.error_code = ERR_BAD_COUNT;
      end else if (hdr_flag_bad) begin
        out_nxt.kind       = KIND_ERROR;
        out_nxt.error_code = ERR_FIRST_MISM;
      end else begin
        out_nxt.kind = KIND_HEADER;
      end
    end else if (phase_r == PH_BODY) begin
      if (body_desc) begin
        out_nxt.kind       = KIND_ERROR;
        out_nxt.error_code = ERR_DESCENDING;
      end else if (body_beyond) begin
        out_nxt.kind       = KIND_ERROR;
        out_nxt.error_code = ERR_BEYOND;
      end else if (body_last && body_last_bad) begin
        out_nxt.kind       = KIND_ERROR;
        out_nxt.error_code = ERR_LAST_MISM;
      end else begin
        out_nxt.kind         = body_last ? KIND_FINAL : KIND_ENTRY;
        out_nxt.entry_index  = IDX_W'(word_index_r - CNT_W'(1));
        out_nxt.entry_offset = prev_off_r;
        out_nxt.entry_size   = masked - prev_off_r;
        out_nxt.entry_flag   = prev_flag_r;
      end
    end
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r       <= '0;
      phase_r      <= PH_IDLE;
      word_index_r <= '0;
      word_count_r <= '0;
      prev_off_r   <= '0;
      prev_flag_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_if.valid) begin
        size_r <= cfg_if.data;
      end
      phase_r      <= phase_nxt;
      word_index_r <= word_index_nxt;
      word_count_r <= word_count_nxt;
      prev_off_r   <= prev_off_nxt;
      prev_flag_r  <= prev_flag_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      out_r <= out_nxt;
    end
  end

endmodule
